@@ sv/hsv_h2r_pkg.sv @@
package hsv_h2r_pkg;

   typedef enum logic [1:0] {
      MODE_HSV      = 2'd0,
      MODE_LINEAR   = 2'd1,
      MODE_WHEEL    = 2'd2,
      MODE_REGIONAL = 2'd3
   } mode_type;

   // HSV sectors, named by the full channel and then the ramp channel.
   typedef enum logic [2:0] {
      SECT_R_G = 3'd0,
      SECT_G_R = 3'd1,
      SECT_G_B = 3'd2,
      SECT_B_G = 3'd3,
      SECT_B_R = 3'd4,
      SECT_R_B = 3'd5
   } sector_type;

   typedef enum logic [1:0] {
      REGION_RG = 2'd0,
      REGION_GB = 2'd1,
      REGION_BR = 2'd2
   } region_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      mode_type   mode;
      logic       grey;
      sector_type sector;
      logic [7:0] value;
      logic [15:0] span;
      region_type region;
      logic [6:0] step;
      logic [6:0] wheel_red;
      logic [6:0] wheel_green;
      logic [6:0] wheel_blue;
   } s1_type;

   typedef struct packed {
      mode_type   mode;
      logic       grey;
      sector_type sector;
      logic [7:0] value;
      logic [23:0] product;
      rsp_type    alt;
   } s2_type;

   typedef struct packed {
      s2_type     base;
      logic [7:0] estimate;
   } s3_type;

   localparam logic [15:0] FULL_SCALE = 16'd65025;
   // floor(2^32 / 65025); the estimate is low by at most one.
   localparam logic [16:0] DIV_RECIP  = 17'd66051;
   localparam int          DIV_SHIFT  = 32;

   localparam int  WHEEL_DEPTH  = 128;
   localparam int  REGION_DEPTH = 85;
   localparam real PI = 3.14159265358979323846;

   typedef logic [7:0] wheel_tbl_type [WHEEL_DEPTH];
   typedef logic [7:0] region_tbl_type [REGION_DEPTH];

   // Entry j holds floor(255 * sin^2(pi * (6j + 3) / 1530)).
   function automatic wheel_tbl_type build_wheel_tbl();
      wheel_tbl_type tbl;
      real           ang;
      for (int j = 0; j < WHEEL_DEPTH; j++) begin
         ang    = PI * real'(6 * j + 3) / 1530.0;
         tbl[j] = 8'($rtoi(255.0 * $sin(ang) * $sin(ang)));
      end
      tbl[WHEEL_DEPTH - 1] = 8'd255;
      return tbl;
   endfunction

   // Entry n holds floor(255 * sin^2(pi * 9n / 1530)).
   function automatic region_tbl_type build_region_tbl();
      region_tbl_type tbl;
      real            ang;
      for (int n = 0; n < REGION_DEPTH; n++) begin
         ang    = PI * real'(9 * n) / 1530.0;
         tbl[n] = 8'($rtoi(255.0 * $sin(ang) * $sin(ang)));
      end
      return tbl;
   endfunction

   localparam wheel_tbl_type  WHEEL_TBL  = build_wheel_tbl();
   localparam region_tbl_type REGION_TBL = build_region_tbl();

endpackage

@@ sv/hsv_h2r_decode.sv @@
module hsv_h2r_decode (
   input  logic                clock,
   input  logic                reset,
   input  hsv_h2r_pkg::mode_type mode,
   input  logic                in_valid,
   output logic                in_stall,
   input  hsv_h2r_pkg::req_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output hsv_h2r_pkg::s1_type out_data
);

   localparam logic [8:0] OFFSET_RED   = 9'd127;
   localparam logic [8:0] OFFSET_GREEN = 9'd42;
   localparam logic [8:0] OFFSET_BLUE  = 9'd212;

   // The wheel angle 6*hue + 6*offset + 3 is folded into the first half turn.
   function automatic logic [6:0] wheel_index(input logic [7:0] hue,
                                              input logic [8:0] offset);
      logic [8:0] sum;
      logic [7:0] m;
      sum = {1'b0, hue} + offset;
      m   = (sum >= 9'd255) ? 8'(sum - 9'd255) : sum[7:0];
      return (m >= 8'd128) ? 7'(8'd254 - m) : m[6:0];
   endfunction

   logic                valid_ff, valid_in;
   hsv_h2r_pkg::s1_type data_ff, data_in;
   logic                ready;
   logic [7:0]          hue_w;
   logic [10:0]         h6;
   logic [8:0]          r;
   logic [7:0]          d;
   logic [15:0]         sd;

   assign ready    = !valid_ff || !out_stall;
   assign in_stall = !ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_comb begin
      hue_w = (in_data.hue == 8'd255) ? 8'd0 : in_data.hue;
      h6    = 11'(hue_w) * 11'd6;
      if (h6 >= 11'd1020) begin
         r = 9'(h6 - 11'd1020);
      end else if (h6 >= 11'd510) begin
         r = 9'(h6 - 11'd510);
      end else begin
         r = h6[8:0];
      end
      d  = (r >= 9'd255) ? 8'(r - 9'd255) : 8'(9'd255 - r);
      sd = 16'(in_data.saturation) * 16'(d);

      data_in.mode  = mode;
      data_in.grey  = (in_data.saturation == 8'd0);
      data_in.value = in_data.brightness;
      data_in.span  = hsv_h2r_pkg::FULL_SCALE - sd;

      if (h6 <= 11'd255) begin
         data_in.sector = hsv_h2r_pkg::SECT_R_G;
      end else if (h6 <= 11'd510) begin
         data_in.sector = hsv_h2r_pkg::SECT_G_R;
      end else if (h6 <= 11'd765) begin
         data_in.sector = hsv_h2r_pkg::SECT_G_B;
      end else if (h6 <= 11'd1020) begin
         data_in.sector = hsv_h2r_pkg::SECT_B_G;
      end else if (h6 <= 11'd1275) begin
         data_in.sector = hsv_h2r_pkg::SECT_B_R;
      end else begin
         data_in.sector = hsv_h2r_pkg::SECT_R_B;
      end

      if (hue_w >= 8'd170) begin
         data_in.region = hsv_h2r_pkg::REGION_BR;
         data_in.step   = 7'(hue_w - 8'd170);
      end else if (hue_w >= 8'd85) begin
         data_in.region = hsv_h2r_pkg::REGION_GB;
         data_in.step   = 7'(hue_w - 8'd85);
      end else begin
         data_in.region = hsv_h2r_pkg::REGION_RG;
         data_in.step   = hue_w[6:0];
      end

      // The wheel mode does not wrap hue 255.
      data_in.wheel_red   = wheel_index(in_data.hue, OFFSET_RED);
      data_in.wheel_green = wheel_index(in_data.hue, OFFSET_GREEN);
      data_in.wheel_blue  = wheel_index(in_data.hue, OFFSET_BLUE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/hsv_h2r_scale.sv @@
module hsv_h2r_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  hsv_h2r_pkg::s1_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output hsv_h2r_pkg::s3_type out_data
);

   logic                v2_ff, v2_in, v3_ff, v3_in;
   logic                ready2, ready3;
   hsv_h2r_pkg::s2_type d2_ff, d2_in;
   hsv_h2r_pkg::s3_type d3_ff, d3_in;
   logic [7:0]          ramp;
   logic [40:0]         recip_prod;

   assign ready3   = !v3_ff || !out_stall;
   assign ready2   = !v2_ff || ready3;
   assign in_stall = !ready2;
   assign v2_in    = ready2 ? in_valid : v2_ff;
   assign v3_in    = ready3 ? v2_ff : v3_ff;

   // Product stage, plus the colours of the hue-only modes: table lookups, or a ramp of 3*step in linear mode.
   always_comb begin
      d2_in.mode    = in_data.mode;
      d2_in.grey    = in_data.grey;
      d2_in.sector  = in_data.sector;
      d2_in.value   = in_data.value;
      d2_in.product = 24'(in_data.span) * 24'(in_data.value);

      if (in_data.mode == hsv_h2r_pkg::MODE_LINEAR) begin
         ramp = 8'(in_data.step) * 8'd3;
      end else begin
         ramp = hsv_h2r_pkg::REGION_TBL[in_data.step];
      end

      if (in_data.mode == hsv_h2r_pkg::MODE_WHEEL) begin
         d2_in.alt.red   = hsv_h2r_pkg::WHEEL_TBL[in_data.wheel_red];
         d2_in.alt.green = hsv_h2r_pkg::WHEEL_TBL[in_data.wheel_green];
         d2_in.alt.blue  = hsv_h2r_pkg::WHEEL_TBL[in_data.wheel_blue];
      end else begin
         case (in_data.region)
            hsv_h2r_pkg::REGION_RG: begin
               d2_in.alt.red   = 8'd255 - ramp;
               d2_in.alt.green = ramp;
               d2_in.alt.blue  = 8'd0;
            end
            hsv_h2r_pkg::REGION_GB: begin
               d2_in.alt.red   = 8'd0;
               d2_in.alt.green = 8'd255 - ramp;
               d2_in.alt.blue  = ramp;
            end
            default: begin
               d2_in.alt.red   = ramp;
               d2_in.alt.green = 8'd0;
               d2_in.alt.blue  = 8'd255 - ramp;
            end
         endcase
      end
   end

   // Reciprocal stage: estimate of product / 65025.
   always_comb begin
      recip_prod     = 41'(d2_ff.product) * 41'(hsv_h2r_pkg::DIV_RECIP);
      d3_in.base     = d2_ff;
      d3_in.estimate = recip_prod[hsv_h2r_pkg::DIV_SHIFT + 7 : hsv_h2r_pkg::DIV_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && in_valid) begin
         d2_ff <= d2_in;
      end
      if (ready3 && v2_ff) begin
         d3_ff <= d3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

@@ sv/hsv_h2r_output.sv @@
module hsv_h2r_output (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  hsv_h2r_pkg::s3_type  in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hsv_h2r_pkg::rsp_type out_data
);

   logic                 valid_ff, valid_in;
   hsv_h2r_pkg::rsp_type data_ff, data_in;
   logic                 ready;
   logic [23:0]          back;
   logic [23:0]          rem;
   logic [7:0]           x;
   logic [7:0]           c;

   assign ready    = !valid_ff || !out_stall;
   assign in_stall = !ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_comb begin
      // The estimate is never high, so one correction step finishes the quotient.
      back = 24'(in_data.estimate) * 24'(hsv_h2r_pkg::FULL_SCALE);
      rem  = in_data.base.product - back;
      x    = (rem >= 24'(hsv_h2r_pkg::FULL_SCALE)) ? in_data.estimate + 8'd1
                                                   : in_data.estimate;
      c    = in_data.base.value;

      if (in_data.base.mode != hsv_h2r_pkg::MODE_HSV) begin
         data_in = in_data.base.alt;
      end else if (in_data.base.grey) begin
         data_in = '{red: c, green: c, blue: c};
      end else begin
         case (in_data.base.sector)
            hsv_h2r_pkg::SECT_R_G: data_in = '{red: c,    green: x,    blue: 8'd0};
            hsv_h2r_pkg::SECT_G_R: data_in = '{red: x,    green: c,    blue: 8'd0};
            hsv_h2r_pkg::SECT_G_B: data_in = '{red: 8'd0, green: c,    blue: x};
            hsv_h2r_pkg::SECT_B_G: data_in = '{red: 8'd0, green: x,    blue: c};
            hsv_h2r_pkg::SECT_B_R: data_in = '{red: x,    green: 8'd0, blue: c};
            default:               data_in = '{red: c,    green: 8'd0, blue: x};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/hsv_hue_to_rgb_converter_core.sv @@
// A request is accepted into the decode register, then passes the product, reciprocal and
// output registers, four pipeline registers in all, before its response is valid.
// Throughput: one transaction per cycle unless stalled; the four registers carry their
// own valid bits and advance independently, so a stall at the output only holds full stages.
// The product multiply and the reciprocal multiply of the divide by 65025 each own a stage.
// Reset (synchronous, active high) empties the pipeline and sets the mode to HSV.
module hsv_hue_to_rgb_converter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hsv_h2r_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsv_h2r_pkg::rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_write_data
);

   hsv_h2r_pkg::mode_type conversion_mode_ff, conversion_mode_in;
   logic                  s1_valid, s1_stall, s3_valid, s3_stall;
   hsv_h2r_pkg::s1_type   s1_data;
   hsv_h2r_pkg::s3_type   s3_data;

   assign conversion_mode_in = csr_write_enable ? hsv_h2r_pkg::mode_type'(csr_write_data)
                                                : conversion_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conversion_mode_ff <= hsv_h2r_pkg::MODE_HSV;
      end else begin
         conversion_mode_ff <= conversion_mode_in;
      end
   end

   hsv_h2r_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .mode      (conversion_mode_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .out_data  (s1_data)
   );

   hsv_h2r_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_stall (s3_stall),
      .out_data  (s3_data)
   );

   hsv_h2r_output u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_stall  (s3_stall),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule
